### rtl/core/bounded_deque_macros.svh
// Assertion macros used by the top RTL file of the deque.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Operation codes carried by the opcode field.
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_READ_INDEX = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    // Completion codes reported with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/core/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port: a write or a registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output bdq_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new transaction may be taken while the previous result is shown.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = start ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake and datapath commands.
    assign busy     = (state_reg == S_EXEC);
    assign done     = (state_reg == S_RESP);
    assign cmd.load = start && !busy;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

`default_nettype wire

### rtl/core/bdq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_datapath #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bdq_pkg::ctrl_cmd_t cmd,
    input  wire logic               cfg_wr_en,
    input  wire logic [8:0]         cfg_wr_data,
    input  wire logic [2:0]         opcode,
    input  wire logic [31:0]        push_value,
    input  wire logic [7:0]         position,
    output logic      [31:0]        read_value,
    output logic      [1:0]         status,
    output logic      [8:0]         entry_count,
    output logic                    is_empty,
    output logic                    is_full
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int OW   = (CW > 8) ? CW : 8;
    localparam int SW   = OW + 1;
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam int XW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    // Operation registers, loaded when a transaction is accepted.
    bdq_pkg::op_t            op_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic [7:0]              pos_reg;

    // Queue state and configuration.
    logic [AW-1:0]           front_reg;
    logic [AW-1:0]           front_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [8:0]              limit_reg;

    // Result registers.
    bdq_pkg::status_t        status_reg;
    bdq_pkg::status_t        status_next;
    logic [DATA_WIDTH-1:0]   result_reg;
    logic [DATA_WIDTH-1:0]   result_next;
    logic                    use_rd_reg;
    logic                    use_rd_next;

    // Memory port.
    logic                    ram_en;
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    logic [XW-1:0]           push_x;
    logic [XW-1:0]           read_x;
    logic [DATA_WIDTH-1:0]   read_sel;
    logic [CMPW-1:0]         limit_w;
    logic [CMPW-1:0]         depth_w;
    logic [CMPW-1:0]         cap_w;
    logic [CMPW-1:0]         count_w;
    logic                    full;
    logic                    empty;
    logic [SW-1:0]           front_s;
    logic [AW-1:0]           back_slot;
    logic [AW-1:0]           last_slot;
    logic [AW-1:0]           index_slot;
    logic [AW-1:0]           front_inc;
    logic [AW-1:0]           front_dec;

    // Reduce a sum below twice the depth to a slot of the ring.
    function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
        logic [SW-1:0] reduced;
        reduced = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
        return reduced[AW-1:0];
    endfunction

    // Stored values keep DATA_WIDTH bits of the pushed value.
    assign push_x = XW'(push_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= bdq_pkg::OP_NONE;
            val_reg <= '0;
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            op_reg  <= bdq_pkg::op_t'(opcode);
            val_reg <= push_x[DATA_WIDTH-1:0];
            pos_reg <= position;
        end
    end

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd0;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Effective capacity and occupancy flags.
    assign limit_w = CMPW'(limit_reg);
    assign depth_w = CMPW'(DEPTH);
    assign cap_w   = ((limit_w == '0) || (limit_w > depth_w)) ? depth_w : limit_w;
    assign count_w = CMPW'(count_reg);
    assign full    = (count_w >= cap_w);
    assign empty   = (count_reg == '0);

    // Ring slot arithmetic.
    assign front_s    = SW'(front_reg);
    assign back_slot  = wrap_slot(front_s + SW'(count_reg));
    assign last_slot  = wrap_slot(front_s + SW'(count_reg) - SW'(1));
    assign index_slot = wrap_slot(front_s + SW'(pos_reg));
    assign front_inc  = wrap_slot(front_s + SW'(1));
    assign front_dec  = (front_reg == '0) ? AW'(DEPTH - 1) : (front_reg - AW'(1));

    // Operation decode: at most one memory access and the pointer and count update.
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = bdq_pkg::ST_OK;
        result_next = '0;
        use_rd_next = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = back_slot;
        unique case (op_reg)
            bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = bdq_pkg::ST_FULL;
                end
                else
                begin
                    ram_en      = cmd.exec;
                    ram_we      = 1'b1;
                    count_next  = count_reg + CW'(1);
                    result_next = val_reg;
                    if (op_reg == bdq_pkg::OP_PUSH_FRONT)
                    begin
                        ram_addr   = front_dec;
                        front_next = front_dec;
                    end
                end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_PEEK_FRONT,
            bdq_pkg::OP_POP_BACK, bdq_pkg::OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    status_next = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_en      = cmd.exec;
                    use_rd_next = 1'b1;
                    if ((op_reg == bdq_pkg::OP_POP_FRONT) ||
                        (op_reg == bdq_pkg::OP_PEEK_FRONT))
                    begin
                        ram_addr = front_reg;
                    end
                    else
                    begin
                        ram_addr = last_slot;
                    end
                    if (op_reg == bdq_pkg::OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                    else if (op_reg == bdq_pkg::OP_POP_BACK)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            bdq_pkg::OP_READ_INDEX:
            begin
                if (OW'(pos_reg) >= OW'(count_reg))
                begin
                    status_next = bdq_pkg::ST_RANGE;
                end
                else
                begin
                    ram_en      = cmd.exec;
                    use_rd_next = 1'b1;
                    ram_addr    = index_slot;
                end
            end
            default:
            begin
                status_next = bdq_pkg::ST_OK;
            end
        endcase
    end

    // State update at the end of the execute cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            use_rd_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            use_rd_reg <= use_rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    // Result ports.
    assign read_sel    = use_rd_reg ? ram_rdata : result_reg;
    assign read_x      = XW'(read_sel);
    assign read_value  = read_x[31:0];
    assign status      = status_reg;
    assign entry_count = 9'(count_w);
    assign is_empty    = empty;
    assign is_full     = full;

endmodule

`default_nettype wire

### rtl/core/bounded_deque.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_macros.svh"

// Bounded double-ended queue with indexed read, kept in a ring buffer.
// Command channel: an operation (opcode, push_value, position) is taken at a
// rising edge where start is high and busy is low. Opcodes push at the back or
// front, pop or peek at either end, or read the entry at a position from the
// front; the unused opcode changes nothing and reports ok.
// Result channel: done is high for exactly one cycle, in the result state that
// ends the accepted operation, with read_value, status, entry_count, is_empty and is_full.
// The receiver cannot hold results off; they must be taken in that cycle.
// The element store is a single port RAM with a registered read, so each
// transaction makes its memory access in the execute state and then shows its
// result in the result state; the next start may be taken in the result
// state, but not in the execute state, where busy is high.
// Configuration: cfg_wr_en writes cfg_wr_data to the capacity limit (zero means
// the full depth). Write it only while no transaction is in flight.
// Reset: rst_n clears the pointers, the count and the limit at once; the store
// itself is not cleared and needs no sweep, since only pushed slots are read.
module bounded_deque #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  opcode,
    input  wire logic [31:0] push_value,
    input  wire logic [7:0]  position,
    output logic             done,
    output logic      [31:0] read_value,
    output logic      [1:0]  status,
    output logic      [8:0]  entry_count,
    output logic             is_empty,
    output logic             is_full,
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data
);

    bdq_pkg::ctrl_cmd_t cmd;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .push_value  (push_value),
        .position    (position),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    // An accepted transaction executes next cycle and reports the cycle after.
    `BDQ_ASSERT_NEXT(a_accept_exec, start && !busy, busy && cmd.exec, "accepted op not executed")
    `BDQ_ASSERT_NEXT(a_exec_done, busy, done, "executed op gave no result")
    `BDQ_ASSERT_NOW(a_done_free, done, !busy && !cmd.exec, "result shown while executing")
    // An empty report carries a zero value and an empty queue.
    `BDQ_ASSERT_NOW(a_empty_zero, done && (status == bdq_pkg::ST_EMPTY), is_empty && (read_value == 32'd0), "empty report inconsistent")
    // A rejected push leaves the queue at its capacity.
    `BDQ_ASSERT_NOW(a_full_flag, done && (status == bdq_pkg::ST_FULL), is_full && (read_value == 32'd0), "full report inconsistent")

endmodule

`default_nettype wire
